### src/ebft_pkg.sv
// ============================================================================
// ebft_pkg: shared types and constants of the encoder and button tuner
// Field widths, value limits, reset values and the structs that carry an
// input item, the configuration, the tuner state and one result.
// ============================================================================
`timescale 1ns / 1ps

package ebft_pkg;

    localparam int TimeW    = 32;
    localparam int ValW     = 12;
    localparam int StepW    = 8;
    localparam int LockW    = 8;
    localparam int PressW   = 16;
    localparam int CfgDataW = 16;
    localparam int CfgIdxW  = 2;

    localparam logic [ValW-1:0] ValMin  = 12'd50;
    localparam logic [ValW-1:0] ValMax  = 12'd3000;
    localparam logic [ValW-1:0] BwHigh  = 12'd1000;
    localparam logic [ValW-1:0] BwLow   = 12'd50;
    localparam logic [ValW-1:0] BwMid   = 12'((1000 + 50) / 2);
    localparam logic [ValW-1:0] BwReset = 12'd150;
    localparam logic [ValW-1:0] CfReset = 12'd700;

    localparam logic [StepW-1:0]  StepReset  = 8'd10;
    localparam logic [LockW-1:0]  LockReset  = 8'd5;
    localparam logic [PressW-1:0] LongReset  = 16'd1000;
    localparam logic [PressW-1:0] ShortReset = 16'd150;

    localparam logic ModeEncoder = 1'b0;
    localparam logic ModeButton  = 1'b1;
    localparam logic BtnPressed  = 1'b0;
    localparam logic PageBw      = 1'b0;

    typedef enum logic [CfgIdxW-1:0] {
        CfgStep    = 2'd0,
        CfgLockout = 2'd1,
        CfgLong    = 2'd2,
        CfgShort   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             mode;
        logic [TimeW-1:0] time_ms;
        logic             enc_clk;
        logic             enc_dt;
        logic             button_level;
    } t_item;

    typedef struct packed {
        logic [StepW-1:0]  step_hz;
        logic [LockW-1:0]  lockout_ms;
        logic [PressW-1:0] long_press_ms;
        logic [PressW-1:0] short_press_ms;
    } t_cfg;

    typedef struct packed {
        logic             prev_clk;
        logic [TimeW-1:0] step_stamp;
        logic [TimeW-1:0] press_stamp;
        logic [ValW-1:0]  bw_value;
        logic [ValW-1:0]  cf_value;
        logic             page_sel;
    } t_state;

    typedef struct packed {
        logic [ValW-1:0] bandwidth_hz;
        logic [ValW-1:0] center_hz;
        logic            page;
        logic            changed;
    } t_result;

endpackage

### src/ebft_in_if.sv
// ============================================================================
// ebft_in_if: input channel of the tuner
// Valid/ready channel that carries one encoder check or button edge event.
// ============================================================================
`timescale 1ns / 1ps

interface ebft_in_if;
    import ebft_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [TimeW-1:0] time_ms;
    logic             enc_clk;
    logic             enc_dt;
    logic             button_level;

    modport source (
        output valid, mode, time_ms, enc_clk, enc_dt, button_level,
        input  ready
    );

    modport sink (
        input  valid, mode, time_ms, enc_clk, enc_dt, button_level,
        output ready
    );
endinterface

### src/ebft_out_if.sv
// ============================================================================
// ebft_out_if: result channel of the tuner
// Valid/ready channel that carries the filter settings after each item.
// ============================================================================
`timescale 1ns / 1ps

interface ebft_out_if;
    import ebft_pkg::*;

    logic            valid;
    logic            ready;
    logic [ValW-1:0] bandwidth_hz;
    logic [ValW-1:0] center_hz;
    logic            page;
    logic            changed;

    modport source (
        output valid, bandwidth_hz, center_hz, page, changed,
        input  ready
    );

    modport sink (
        input  valid, bandwidth_hz, center_hz, page, changed,
        output ready
    );
endinterface

### src/encoder_button_filter_tuner_core.sv
// ============================================================================
// encoder_button_filter_tuner_core: encoder and button tuner for a filter
// An accepted transaction is held in the input register and then moves into the result register.
// Throughput: one transaction per clock unless the result channel stalls, set by the loop from
// the tuner state through the update logic back into the state registers.
// Reset: synchronous, active low; clears both channels, restores the
// configuration defaults and the tuner state (bandwidth 150, center 700).
// ============================================================================
`timescale 1ns / 1ps

module encoder_button_filter_tuner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ebft_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ebft_pkg::CfgDataW-1:0] i_cfg_data,
    ebft_in_if.sink                       i_in,
    ebft_out_if.source                    o_out
);
    import ebft_pkg::*;

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    t_cfg    r_cfg;

    // Input register: holds one accepted transaction until it is processed.
    logic    r_in_valid;
    t_item   r_in;

    // Tuner state, updated once per processed transaction.
    t_state  r_state;

    // Result register: decouples the result channel from the input side.
    logic    r_out_valid;
    t_result r_out;

    t_state  n_state;
    t_result n_out;
    t_item   w_item;
    logic    w_advance;

    assign w_item.mode         = i_in.mode;
    assign w_item.time_ms      = i_in.time_ms;
    assign w_item.enc_clk      = i_in.enc_clk;
    assign w_item.enc_dt       = i_in.enc_dt;
    assign w_item.button_level = i_in.button_level;

    // The staged item moves into the result register whenever that register
    // is empty or its content is being taken in the same cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    ebft_update u_update (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_cfg.step_hz        <= StepReset;
            r_cfg.lockout_ms     <= LockReset;
            r_cfg.long_press_ms  <= LongReset;
            r_cfg.short_press_ms <= ShortReset;
            r_state.prev_clk     <= 1'b1;
            r_state.step_stamp   <= '0;
            r_state.press_stamp  <= '0;
            r_state.bw_value     <= BwReset;
            r_state.cf_value     <= CfReset;
            r_state.page_sel     <= PageBw;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CfgStep:    r_cfg.step_hz        <= i_cfg_data[StepW-1:0];
                    CfgLockout: r_cfg.lockout_ms     <= i_cfg_data[LockW-1:0];
                    CfgLong:    r_cfg.long_press_ms  <= i_cfg_data[PressW-1:0];
                    CfgShort:   r_cfg.short_press_ms <= i_cfg_data[PressW-1:0];
                    default:    r_cfg                <= r_cfg;
                endcase
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in <= w_item;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bandwidth_hz = r_out.bandwidth_hz;
    assign o_out.center_hz    = r_out.center_hz;
    assign o_out.page         = r_out.page;
    assign o_out.changed      = r_out.changed;

    // Both tuned values always stay inside the saturation limits.
    a_bw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.bandwidth_hz >= ValMin && r_out.bandwidth_hz <= ValMax))
        else $error("bandwidth outside limits");

    a_cf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.center_hz >= ValMin && r_out.center_hz <= ValMax))
        else $error("center frequency outside limits");

    // A button press only records its time and never changes a setting.
    a_press_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.mode == ModeButton && r_in.button_level == BtnPressed)
        |=> !r_out.changed)
        else $error("button press changed a setting");

    // The page only moves when a transaction is processed.
    a_page_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state.page_sel))
        else $error("page changed without a transaction");

    // With both registers full and the result stalled, no input is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline is full");
endmodule

### src/ebft_update.sv
// ============================================================================
// ebft_update: next-state logic of the tuner
// Works out the new tuner state and the result for one item in one pass.
// ============================================================================
`timescale 1ns / 1ps

module ebft_update (
    input  ebft_pkg::t_item   i_item,
    input  ebft_pkg::t_cfg    i_cfg,
    input  ebft_pkg::t_state  i_state,
    output ebft_pkg::t_state  o_state,
    output ebft_pkg::t_result o_result
);
    import ebft_pkg::*;

    logic [ValW-1:0]  w_sel;
    logic [ValW:0]    w_up_sum;
    logic [ValW:0]    w_dn_floor;
    logic [ValW-1:0]  w_up_val;
    logic [ValW-1:0]  w_dn_val;
    logic [ValW-1:0]  w_moved;
    logic [TimeW-1:0] w_elapsed;
    logic [TimeW-1:0] w_dur;
    logic             w_open;
    logic             w_fall;
    logic             w_long;
    logic             w_short;
    t_state           w_next;

    // Saturating step of the value that the page selects.
    assign w_sel      = i_state.page_sel ? i_state.cf_value : i_state.bw_value;
    assign w_up_sum   = {1'b0, w_sel} + {{(ValW + 1 - StepW){1'b0}}, i_cfg.step_hz};
    assign w_dn_floor = {{(ValW + 1 - StepW){1'b0}}, i_cfg.step_hz} + {1'b0, ValMin};
    assign w_up_val   = (w_up_sum > {1'b0, ValMax}) ? ValMax : w_up_sum[ValW-1:0];
    assign w_dn_val   = ({1'b0, w_sel} < w_dn_floor) ? ValMin
                      : w_sel - {{(ValW - StepW){1'b0}}, i_cfg.step_hz};
    assign w_moved    = i_item.enc_dt ? w_up_val : w_dn_val;

    // Time differences wrap modulo 2^32, as the timestamp does.
    assign w_elapsed = i_item.time_ms - i_state.step_stamp;
    assign w_dur     = i_item.time_ms - i_state.press_stamp;
    assign w_open    = w_elapsed >= {{(TimeW - LockW){1'b0}}, i_cfg.lockout_ms};
    assign w_fall    = !i_item.enc_clk && i_state.prev_clk;
    assign w_long    = w_dur > {{(TimeW - PressW){1'b0}}, i_cfg.long_press_ms};
    assign w_short   = w_dur > {{(TimeW - PressW){1'b0}}, i_cfg.short_press_ms};

    always_comb begin
        w_next = i_state;
        if (i_item.mode == ModeEncoder) begin
            if (w_open) begin
                w_next.prev_clk = i_item.enc_clk;
                if (w_fall) begin
                    w_next.step_stamp = i_item.time_ms;
                    if (i_state.page_sel == PageBw) begin
                        w_next.bw_value = w_moved;
                    end else begin
                        w_next.cf_value = w_moved;
                    end
                end
            end
        end else if (i_item.button_level == BtnPressed) begin
            w_next.press_stamp = i_item.time_ms;
        end else if (w_long) begin
            if (i_state.page_sel == PageBw) begin
                w_next.bw_value = (i_state.bw_value < BwMid) ? BwHigh : BwLow;
            end
        end else if (w_short) begin
            w_next.page_sel = !i_state.page_sel;
        end
    end

    assign o_state               = w_next;
    assign o_result.bandwidth_hz = w_next.bw_value;
    assign o_result.center_hz    = w_next.cf_value;
    assign o_result.page         = w_next.page_sel;
    assign o_result.changed      = (w_next.bw_value != i_state.bw_value)
                                || (w_next.cf_value != i_state.cf_value)
                                || (w_next.page_sel != i_state.page_sel);
endmodule
